@@ rtl/core/disc_scanline_span_raster_assert.svh @@
// ============================================================================
// Assertion macros for the disc scanline span rasterizer
// Clocked on aclk; the first form is gated off while aresetn is low.
// ============================================================================
`ifndef DISC_SCANLINE_SPAN_RASTER_ASSERT_SVH
`define DISC_SCANLINE_SPAN_RASTER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define DSSR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define DSSR_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define DSSR_ASSERT(label, prop, msg)
`define DSSR_ASSERT_RST(label, prop, msg)
`endif

`endif

@@ rtl/core/dssr_pkg.sv @@
// ============================================================================
// dssr_pkg
// Shared types and constants of the disc scanline span rasterizer.
// ============================================================================
package dssr_pkg;

    localparam int DEFAULT_MAX_RADIUS = 31;
    localparam int QUEUE_DEPTH        = 2;

    localparam int COORD_W  = 10;
    localparam int RADIUS_W = 5;
    localparam int SPAN_W   = 11;
    localparam int WIDTH_W  = 6;
    localparam int DY_W     = RADIUS_W + 1;
    localparam int SQ_W     = 2 * RADIUS_W;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    typedef struct packed {
        logic [RADIUS_W-1:0] r;
        logic [COORD_W-1:0]  cy;
        logic [COORD_W-1:0]  cx;
    } disc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

endpackage

@@ rtl/core/disc_scanline_span_raster.sv @@
// ============================================================================
// disc_scanline_span_raster
// Filled-disc rasterizer: one horizontal span per row of a disc.
// ============================================================================
// A disc (center_x, center_y, radius) enters on the s_ stream channel; the
// block returns 2*radius+1 spans on the m_ channel, top row first, with
// m_tlast set on the bottom row's span. A radius above MAX_RADIUS is clamped.
// Each disc passes through the queue to the row walker, whose spans are held
// in the output register. A disc of radius r keeps the walker busy while the
// half-extent moves one step at a time (r steps up, r steps down), besides
// one step per emitted row; the next disc is popped only once it is done.
// Up to two further discs wait in a queue, so s_tready stays high while a
// disc is being drawn until that queue is full.
// When the receiver holds m_tready low, the current span waits in the output
// register and the row walker stops at its next span; the queue keeps taking discs.
// Reset (aresetn low, synchronous) empties the queue, stops the walker and
// drops any undelivered span.
// ============================================================================
module disc_scanline_span_raster
    import dssr_pkg::*;
#(
    parameter int MAX_RADIUS = DEFAULT_MAX_RADIUS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // center_x[9:0], center_y[19:10], radius[24:20]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // span_x[10:0], span_y[21:11], span_width[27:22]
    output logic                 m_tlast    // last_span
);

    logic        push, pop;
    disc_t       push_data, pop_data;
    queue_stat_t stat;

    dssr_front #(
        .MAX_RADIUS(MAX_RADIUS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .stat     (stat),
        .push     (push),
        .push_data(push_data)
    );

    dssr_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .pop_data (pop_data),
        .stat     (stat)
    );

    dssr_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .pop_data(pop_data),
        .stat    (stat),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule

@@ rtl/core/dssr_queue.sv @@
// ============================================================================
// dssr_queue
// Small register queue of pending discs between the front and the back.
// ============================================================================
`include "disc_scanline_span_raster_assert.svh"

module dssr_queue
    import dssr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  disc_t       push_data,
    input  logic        pop,
    output disc_t       pop_data,
    output queue_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    disc_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data   = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

    `DSSR_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "queue count beyond depth")
    `DSSR_ASSERT(a_no_overflow, !(push && stat.full && !pop), "push into a full queue")
    `DSSR_ASSERT(a_no_underflow, !(pop && stat.empty), "pop from an empty queue")

endmodule

@@ rtl/core/dssr_front.sv @@
// ============================================================================
// dssr_front
// Accepts disc transactions, unpacks them and clamps the radius.
// ============================================================================
module dssr_front
    import dssr_pkg::*;
#(
    parameter int MAX_RADIUS = DEFAULT_MAX_RADIUS
) (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // center_x, center_y, radius
    input  queue_stat_t          stat,
    output logic                 push,
    output disc_t                push_data
);

    logic [RADIUS_W-1:0] radius_in;

    assign radius_in = s_tdata[2*COORD_W +: RADIUS_W];

    assign s_tready     = !stat.full;
    assign push         = s_tvalid && !stat.full;
    assign push_data.cx = s_tdata[0 +: COORD_W];
    assign push_data.cy = s_tdata[COORD_W +: COORD_W];
    assign push_data.r  = (radius_in > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS)
                                                              : radius_in;

endmodule

@@ rtl/core/dssr_back.sv @@
// ============================================================================
// dssr_back
// Walks the rows of one disc, tracking the half-extent one step per cycle,
// and emits one span per row through an output register.
// ============================================================================
`include "disc_scanline_span_raster_assert.svh"

module dssr_back
    import dssr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  disc_t                pop_data,
    input  queue_stat_t          stat,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // span_x, span_y, span_width
    output logic                 m_tlast    // last_span
);

    back_state_t         state_reg, state_next;
    logic [COORD_W-1:0]  cx_reg, cx_next;
    logic [COORD_W-1:0]  cy_reg, cy_next;
    logic [RADIUS_W-1:0] r_reg, r_next;
    logic [SQ_W-1:0]     rsq_reg, rsq_next;
    logic [DY_W-1:0]     dy_reg, dy_next;
    logic [RADIUS_W-1:0] ext_reg, ext_next;
    logic [SQ_W-1:0]     esq_reg, esq_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [SPAN_W-1:0]   span_x_reg, span_x_next;
    logic [SPAN_W-1:0]   span_y_reg, span_y_next;
    logic [WIDTH_W-1:0]  span_w_reg, span_w_next;
    logic                last_reg, last_next;

    logic [2*DY_W-1:0]   dy_sq;
    logic [SQ_W-1:0]     rem;
    logic [SQ_W:0]       grow_sq;
    logic                grow, shrink, out_free, emit, is_last;
    logic [RADIUS_W:0]   r_wide;

    assign dy_sq    = (2*DY_W)'($signed(dy_reg) * $signed(dy_reg));
    assign rem      = rsq_reg - dy_sq[SQ_W-1:0];
    assign grow_sq  = {1'b0, esq_reg} + {{(SQ_W - RADIUS_W){1'b0}}, ext_reg, 1'b1};
    assign grow     = grow_sq <= {1'b0, rem};
    assign shrink   = esq_reg > rem;
    assign out_free = !m_tvalid_reg || m_tready;
    assign is_last  = (dy_reg == {1'b0, r_reg});
    assign emit     = (state_reg == BK_RUN) && !grow && !shrink && out_free;
    assign pop      = (state_reg == BK_IDLE) && !stat.empty;
    assign r_wide   = {1'b0, pop_data.r};

    always_comb begin
        state_next    = state_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        r_next        = r_reg;
        rsq_next      = rsq_reg;
        dy_next       = dy_reg;
        ext_next      = ext_reg;
        esq_next      = esq_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        span_x_next   = span_x_reg;
        span_y_next   = span_y_reg;
        span_w_next   = span_w_reg;
        last_next     = last_reg;
        case (state_reg)
            BK_IDLE: begin
                if (pop) begin
                    state_next = BK_RUN;
                    cx_next    = pop_data.cx;
                    cy_next    = pop_data.cy;
                    r_next     = pop_data.r;
                    rsq_next   = SQ_W'({{RADIUS_W{1'b0}}, pop_data.r}
                                       * {{RADIUS_W{1'b0}}, pop_data.r});
                    dy_next    = DY_W'(0) - r_wide;
                    ext_next   = '0;
                    esq_next   = '0;
                end
            end
            BK_RUN: begin
                // The extent settles on floor(sqrt(rem)) one step at a time
                // before the row is emitted.
                if (grow) begin
                    ext_next = ext_reg + 1'b1;
                    esq_next = grow_sq[SQ_W-1:0];
                end else if (shrink) begin
                    ext_next = ext_reg - 1'b1;
                    esq_next = esq_reg - {{(SQ_W - RADIUS_W - 1){1'b0}},
                                          ext_reg - 1'b1, 1'b1};
                end else if (out_free) begin
                    m_tvalid_next = 1'b1;
                    span_x_next   = {cx_reg[COORD_W-1], cx_reg}
                                    - {{(SPAN_W - RADIUS_W){1'b0}}, ext_reg};
                    span_y_next   = {cy_reg[COORD_W-1], cy_reg}
                                    + {{(SPAN_W - DY_W){dy_reg[DY_W-1]}}, dy_reg};
                    span_w_next   = {ext_reg, 1'b1};
                    last_next     = is_last;
                    if (is_last) begin
                        state_next = BK_IDLE;
                    end else begin
                        dy_next = dy_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        r_reg      <= r_next;
        rsq_reg    <= rsq_next;
        dy_reg     <= dy_next;
        ext_reg    <= ext_next;
        esq_reg    <= esq_next;
        span_x_reg <= span_x_next;
        span_y_reg <= span_y_next;
        span_w_reg <= span_w_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{(M_TDATA_W - 2*SPAN_W - WIDTH_W){1'b0}},
                       span_w_reg, span_y_reg, span_x_reg};

    `DSSR_ASSERT_RST(a_reset_idle, !aresetn |=> (state_reg == BK_IDLE && !m_tvalid_reg),
        "back end not idle after reset")
    `DSSR_ASSERT(a_ext_bound, (state_reg == BK_RUN) |-> (ext_reg <= r_reg),
        "half-extent exceeds radius")
    `DSSR_ASSERT(a_dy_bound, (state_reg == BK_RUN) |-> ($signed(dy_reg) <= $signed(DY_W'(r_reg))),
        "row offset past the bottom row")
    `DSSR_ASSERT(a_last_ends, (emit && is_last) |=> (state_reg == BK_IDLE && m_tlast),
        "last span did not end the disc")
    `DSSR_ASSERT(a_width_odd, m_tvalid_reg |-> span_w_reg[0], "span width is even")

endmodule
